[design/lbbc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbbc_pkg
// Types, codes and constants shared by the LED blink and burst controller.
// ----------------------------------------------------------------------------
package lbbc_pkg;

    // Tick counter width; loaded values wrap to it
    localparam int CNT_W = 14;

    localparam logic [13:0] INTERVAL_MIN   = 14'd25;
    localparam logic [13:0] INTERVAL_MAX   = 14'd10000;
    localparam logic [13:0] INTERVAL_RESET = 14'd100;
    localparam logic [6:0]  DUTY_MIN       = 7'd1;
    localparam logic [6:0]  DUTY_MAX       = 7'd100;
    localparam logic [6:0]  DUTY_RESET     = 7'd50;
    localparam logic [7:0]  BURST_MIN      = 8'd2;
    localparam logic [7:0]  BURST_MAX      = 8'd100;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x up to 1e6
    localparam int          RECIP_SHIFT = 27;
    localparam logic [20:0] RECIP_100   = 21'd1342178;
    localparam int          SCALE_W     = 28;
    localparam int          PROD_W      = 14 + SCALE_W;

    typedef logic [SCALE_W-1:0] t_scale_tbl [128];

    function automatic t_scale_tbl build_scale_tbl();
        t_scale_tbl tbl;
        for (int i = 0; i < 128; i++) begin
            tbl[i] = SCALE_W'(i * RECIP_100);
        end
        return tbl;
    endfunction

    // duty * RECIP_100, one entry per duty code
    localparam t_scale_tbl DUTY_SCALE = build_scale_tbl();

    typedef enum logic [2:0] {
        EV_TICK    = 3'd0,
        EV_REPAINT = 3'd1,
        EV_STATUS  = 3'd2,
        EV_BURST   = 3'd3,
        EV_TOGGLE  = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_ON     = 2'd1,
        MODE_BLINK  = 2'd2,
        MODE_SIGNAL = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_INTERVAL = 2'd0,
        CFG_DUTY     = 2'd1,
        CFG_INVERT   = 2'd2,
        CFG_DEFERRED = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] new_status;
        logic [7:0] burst_pulses;
    } t_in_item;

    typedef struct packed {
        logic       pin_level;
        logic       pin_update;
        logic       burst_done;
        logic [1:0] led_mode;
    } t_out_item;

endpackage
`default_nettype wire

[design/led_blink_burst_controller_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_blink_burst_controller_top
// LED pin controller: steady, blinking with duty cycle, and counted bursts.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the input channel (valid/ready) as t_in_item: tick,
//   repaint, set status, start burst or toggle. Every accepted event gives
//   exactly one t_out_item on the output channel: pin level, refresh flag,
//   burst-done flag and current mode.
//   The state update and the result are registered at the edge that accepts
//   the event. Throughput is one event per cycle while the output is not
//   stalled; the path is a 14x28 multiplier (on-time from interval and duty)
//   feeding the on/off time registers, which only configuration writes use.
//   Input ready stays high while the output register is empty or being
//   drained; when the receiver stalls the result holds and ready drops.
//   Configuration: write enable, register index (0 interval, 1 duty,
//   2 invert, 3 deferred refresh) and 14-bit data, applied at once, clamped.
//   Reset (synchronous, active low) gives mode off, pin low, interval 100,
//   duty 50 and a counter loaded with the on time.
// ----------------------------------------------------------------------------
module led_blink_burst_controller_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire lbbc_pkg::t_in_item i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output lbbc_pkg::t_out_item  o_out_data,
    input  wire                  i_cfg_we,
    input  wire  [1:0]           i_cfg_idx,
    input  wire  [13:0]          i_cfg_data
);
    import lbbc_pkg::*;

    // Configuration
    logic [13:0]      r_interval, n_interval;
    logic [6:0]       r_duty, n_duty;
    logic             r_invert, n_invert;
    logic             r_deferred, n_deferred;
    logic [CNT_W-1:0] r_on_time, n_on_time;
    logic [CNT_W-1:0] r_off_time, n_off_time;

    // Controller state
    logic [1:0]       r_mode, n_mode;
    logic [1:0]       r_prior, n_prior;
    logic             r_pin, n_pin;
    logic [CNT_W-1:0] r_tick, n_tick;
    logic [7:0]       r_toggles, n_toggles;

    // Result register
    logic             r_out_valid;
    t_out_item        r_out_data, n_out_data;

    logic             w_accept;
    logic [13:0]      w_int_clamp;
    logic [6:0]       w_duty_clamp;
    logic [7:0]       w_burst_clamp;
    logic [13:0]      w_mul_int;
    logic [6:0]       w_mul_duty;
    logic [PROD_W-1:0] w_prod;
    logic [13:0]      w_on_calc;
    logic             w_upd;
    logic             w_done;
    logic [1:0]       w_status;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Clamp written values and the burst pulse count
    always_comb begin
        if (i_cfg_data < INTERVAL_MIN) begin
            w_int_clamp = INTERVAL_MIN;
        end else if (i_cfg_data > INTERVAL_MAX) begin
            w_int_clamp = INTERVAL_MAX;
        end else begin
            w_int_clamp = i_cfg_data;
        end
        if (i_cfg_data[6:0] < DUTY_MIN) begin
            w_duty_clamp = DUTY_MIN;
        end else if (i_cfg_data[6:0] > DUTY_MAX) begin
            w_duty_clamp = DUTY_MAX;
        end else begin
            w_duty_clamp = i_cfg_data[6:0];
        end
        if (i_in_data.burst_pulses > BURST_MAX) begin
            w_burst_clamp = BURST_MAX;
        end else if (i_in_data.burst_pulses < BURST_MIN) begin
            w_burst_clamp = BURST_MIN;
        end else begin
            w_burst_clamp = i_in_data.burst_pulses;
        end
    end

    // On time = interval * duty / 100, through the reciprocal table
    always_comb begin
        w_mul_int  = r_interval;
        w_mul_duty = r_duty;
        if (i_cfg_idx == CFG_INTERVAL) begin
            w_mul_int = w_int_clamp;
        end
        if (i_cfg_idx == CFG_DUTY) begin
            w_mul_duty = w_duty_clamp;
        end
    end

    assign w_prod    = PROD_W'(w_mul_int) * PROD_W'(DUTY_SCALE[w_mul_duty]);
    assign w_on_calc = w_prod[RECIP_SHIFT +: 14];

    // Configuration writes
    always_comb begin
        n_interval = r_interval;
        n_duty     = r_duty;
        n_invert   = r_invert;
        n_deferred = r_deferred;
        n_on_time  = r_on_time;
        n_off_time = r_off_time;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INTERVAL: begin
                    n_interval = w_int_clamp;
                    n_on_time  = CNT_W'(w_on_calc);
                    n_off_time = CNT_W'(w_int_clamp - w_on_calc);
                end
                CFG_DUTY: begin
                    n_duty     = w_duty_clamp;
                    n_on_time  = CNT_W'(w_on_calc);
                    n_off_time = CNT_W'(r_interval - w_on_calc);
                end
                CFG_INVERT: begin
                    n_invert = i_cfg_data[0];
                end
                CFG_DEFERRED: begin
                    n_deferred = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Event processing
    always_comb begin
        n_mode    = r_mode;
        n_prior   = r_prior;
        n_pin     = r_pin;
        n_tick    = r_tick;
        n_toggles = r_toggles;
        w_upd     = 1'b0;
        w_done    = 1'b0;
        w_status  = i_in_data.new_status;

        if (i_cfg_we) begin
            // Reload the counter on timing writes, repaint steady modes on invert writes unless deferred
            case (i_cfg_idx)
                CFG_INTERVAL, CFG_DUTY: begin
                    n_tick = (r_mode == MODE_SIGNAL) ? CNT_W'(n_interval) : n_on_time;
                end
                CFG_INVERT: begin
                    if (!r_deferred && (r_mode == MODE_OFF || r_mode == MODE_ON)) begin
                        n_pin = r_mode[0] ^ i_cfg_data[0];
                    end
                end
                default: begin
                end
            endcase
        end else if (w_accept) begin
            case (i_in_data.mode)
                EV_TICK: begin
                    if (r_mode == MODE_BLINK) begin
                        if (r_tick != '0) begin
                            n_tick = r_tick - 1'b1;
                        end else if (r_pin) begin
                            n_pin  = 1'b0;
                            n_tick = r_off_time;
                        end else begin
                            n_pin  = 1'b1;
                            n_tick = r_on_time;
                        end
                        w_upd = !r_deferred;
                    end else if (r_mode == MODE_SIGNAL) begin
                        if (r_tick != '0) begin
                            n_tick = r_tick - 1'b1;
                        end else begin
                            n_tick = CNT_W'(r_interval);
                            if (r_toggles != '0) begin
                                n_pin     = !r_pin;
                                n_toggles = r_toggles - 1'b1;
                            end else begin
                                n_mode = r_prior;
                                w_done = 1'b1;
                            end
                        end
                        if (!r_deferred) begin
                            if (n_mode == MODE_OFF || n_mode == MODE_ON) begin
                                n_pin = n_mode[0] ^ r_invert;
                            end
                            w_upd = 1'b1;
                        end
                    end
                end
                EV_REPAINT: begin
                    if (r_mode == MODE_OFF || r_mode == MODE_ON) begin
                        n_pin = r_mode[0] ^ r_invert;
                    end
                    w_upd = 1'b1;
                end
                EV_STATUS: begin
                    if (w_status == MODE_SIGNAL) begin
                        w_status = MODE_BLINK;
                    end
                    n_prior   = r_mode;
                    n_mode    = w_status;
                    n_toggles = '0;
                    if (!r_deferred) begin
                        if (w_status == MODE_OFF || w_status == MODE_ON) begin
                            n_pin = w_status[0] ^ r_invert;
                        end
                        w_upd = 1'b1;
                    end
                end
                EV_BURST: begin
                    n_prior   = r_mode;
                    n_toggles = {w_burst_clamp[6:0], 1'b0} - 8'd1;
                    n_mode    = MODE_SIGNAL;
                    n_pin     = !r_invert;
                    w_upd     = 1'b1;
                end
                EV_TOGGLE: begin
                    if (r_mode == MODE_OFF) begin
                        n_mode  = MODE_ON;
                        n_prior = MODE_OFF;
                    end else if (r_mode == MODE_ON) begin
                        n_mode  = MODE_OFF;
                        n_prior = MODE_ON;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_out_data.pin_level  = n_pin;
        n_out_data.pin_update = w_upd;
        n_out_data.burst_done = w_done;
        n_out_data.led_mode   = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= INTERVAL_RESET;
            r_duty      <= DUTY_RESET;
            r_invert    <= 1'b0;
            r_deferred  <= 1'b0;
            r_on_time   <= CNT_W'(50);
            r_off_time  <= CNT_W'(50);
            r_mode      <= MODE_OFF;
            r_prior     <= MODE_OFF;
            r_pin       <= 1'b0;
            r_tick      <= CNT_W'(50);
            r_toggles   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_interval <= n_interval;
            r_duty     <= n_duty;
            r_invert   <= n_invert;
            r_deferred <= n_deferred;
            r_on_time  <= n_on_time;
            r_off_time <= n_off_time;
            r_mode     <= n_mode;
            r_prior    <= n_prior;
            r_pin      <= n_pin;
            r_tick     <= n_tick;
            r_toggles  <= n_toggles;
            // Hold the result until the receiver takes it
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire
